### src/csda_pkg.sv
// ----------------------------------------------------------------------------
// csda_pkg
// Shared constants, types and state codes for the client sequence-number
// dedup accumulator.
// ----------------------------------------------------------------------------
package csda_pkg;

  // Number of client slots in the table
  localparam int TABLE_SLOTS = 10;
  localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

  // Per-slot snapshot of the last accepted request
  typedef struct packed {
    logic [31:0] seqn;
    logic [31:0] value;
    logic [31:0] count;
    logic [63:0] sum;
  } csda_snap_t;

  localparam int SNAP_W = $bits(csda_snap_t);

  // Registration write into the directory
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [31:0]      addr;
  } csda_reg_t;

  // Directory scan result
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free_ok;
    logic [IDX_W-1:0] free_idx;
  } csda_scan_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_EMIT
  } csda_state_t;

  localparam logic MODE_DISCOVERY = 1'b0;
  localparam logic MODE_REQUEST   = 1'b1;

endpackage

### src/csda_ram.sv
// ----------------------------------------------------------------------------
// csda_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module csda_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/csda_dir.sv
// ----------------------------------------------------------------------------
// csda_dir
// Client directory: valid bits plus an address RAM, walked one slot per
// cycle to find the lowest matching valid slot and the lowest free slot.
// ----------------------------------------------------------------------------
module csda_dir (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         key,
  input  csda_pkg::csda_reg_t wr,
  output csda_pkg::csda_scan_t scan
);
  import csda_pkg::*;

  logic [TABLE_SLOTS-1:0] valid;
  logic                   busy;
  logic [IDX_W-1:0]       rd_idx;
  logic                   cmp_vld;
  logic [IDX_W-1:0]       cmp_idx;
  logic [31:0]            rdata;
  logic                   hit;
  logic [IDX_W-1:0]       hit_idx;
  logic                   free_ok;
  logic [IDX_W-1:0]       free_idx;
  logic                   done;

  csda_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_SLOTS),
    .AW    (IDX_W)
  ) u_addr_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.idx),
    .wdata (wr.addr),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      busy    <= 1'b0;
      cmp_vld <= 1'b0;
      done    <= 1'b0;
      hit     <= 1'b0;
      free_ok <= 1'b0;
      rd_idx  <= '0;
    end else begin
      cmp_vld <= busy;
      done    <= cmp_vld && (cmp_idx == LAST_IDX);
      // compare the slot read in the previous cycle
      if (cmp_vld) begin
        if (!hit && valid[cmp_idx] && (rdata == key)) begin
          hit     <= 1'b1;
          hit_idx <= cmp_idx;
        end
        if (!free_ok && !valid[cmp_idx]) begin
          free_ok  <= 1'b1;
          free_idx <= cmp_idx;
        end
      end
      if (start) begin
        busy    <= 1'b1;
        rd_idx  <= '0;
        hit     <= 1'b0;
        free_ok <= 1'b0;
      end else if (busy) begin
        if (rd_idx == LAST_IDX) begin
          busy <= 1'b0;
        end else begin
          rd_idx <= rd_idx + 1'b1;
        end
      end
      if (wr.we) begin
        valid[wr.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= rd_idx;
  end

  assign scan.done     = done;
  assign scan.hit      = hit;
  assign scan.hit_idx  = hit_idx;
  assign scan.free_ok  = free_ok;
  assign scan.free_idx = free_idx;

endmodule

### src/client_seqn_dedup_accumulator.sv
// ----------------------------------------------------------------------------
// client_seqn_dedup_accumulator
// Client table with discovery registration and sequence-checked requests
// that feed a saturating global request count and running sum.
// ----------------------------------------------------------------------------
// Each accepted transaction walks the directory; a request then reads its
//   snapshot in ST_READ, and the ack is registered out of ST_EMIT.
// Only one transaction is in flight: in_ready is high only in ST_IDLE, so
//   the serial walk over the address RAM, plus any wait for a held ack, sets
//   how soon the next one is taken; a dropped one gets no ack.
// Reset (rst, synchronous): table empty, global count and sum zero, no ack.
// ----------------------------------------------------------------------------
module client_seqn_dedup_accumulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [31:0]        client_addr,
  input  logic [31:0]        req_seqn,
  input  logic signed [31:0] req_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               ack_kind,
  output logic [31:0]        dest_addr,
  output logic               is_duplicate,
  output logic signed [31:0] ack_value,
  output logic [31:0]        ack_seqn,
  output logic [31:0]        ack_num_reqs,
  output logic signed [63:0] ack_total_sum
);
  import csda_pkg::*;

  csda_state_t state, state_next;

  // captured transaction
  logic        mode_q;
  logic [31:0] addr_q;
  logic [31:0] seqn_q;
  logic [31:0] value_q;

  // global accumulators
  logic [31:0] gcount;
  logic [63:0] gsum;

  // staged result
  logic        res_kind;
  logic        res_dup;
  csda_snap_t  res_snap;

  // directory and snapshot RAM
  csda_scan_t  scan;
  csda_reg_t   dir_wr;
  logic        in_acc;
  logic        snap_we;
  logic [IDX_W-1:0] snap_waddr;
  csda_snap_t  snap_wdata;
  logic [SNAP_W-1:0] snap_rdata;
  csda_snap_t  snap_rd;

  // update path
  logic        seq_ok;
  logic [31:0] count_inc;
  logic [63:0] v64;
  logic [63:0] sum_raw;
  logic        sum_ovf;
  logic [63:0] sum_sat;
  csda_snap_t  new_snap;

  // control decodes
  logic        ld_disc;
  logic        ld_req;
  logic        ld_out;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  csda_dir u_dir (
    .clk   (clk),
    .rst   (rst),
    .start (in_acc),
    .key   (addr_q),
    .wr    (dir_wr),
    .scan  (scan)
  );

  // hit_idx holds steady once the walk is done, so the read lands in ST_READ
  csda_ram #(
    .WIDTH (SNAP_W),
    .DEPTH (TABLE_SLOTS),
    .AW    (IDX_W)
  ) u_snap_ram (
    .clk   (clk),
    .we    (snap_we),
    .waddr (snap_waddr),
    .wdata (snap_wdata),
    .raddr (scan.hit_idx),
    .rdata (snap_rdata)
  );

  assign snap_rd = csda_snap_t'(snap_rdata);

  // next expected sequence number wraps modulo 2^32
  assign seq_ok    = ((snap_rd.seqn + 32'd1) == seqn_q);
  assign count_inc = (gcount == 32'hFFFF_FFFF) ? gcount : gcount + 32'd1;
  assign v64       = {{32{value_q[31]}}, value_q};
  assign sum_raw   = gsum + v64;
  assign sum_ovf   = (gsum[63] == v64[63]) && (sum_raw[63] != gsum[63]);
  assign sum_sat   = sum_ovf ? (gsum[63] ? 64'h8000_0000_0000_0000
                                         : 64'h7FFF_FFFF_FFFF_FFFF)
                             : sum_raw;

  always_comb begin
    new_snap.seqn  = seqn_q;
    new_snap.value = value_q;
    new_snap.count = count_inc;
    new_snap.sum   = sum_sat;
  end

  assign ld_out = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dir_wr     = '0;
    snap_we    = 1'b0;
    snap_waddr = scan.hit_idx;
    snap_wdata = new_snap;
    ld_disc    = 1'b0;
    ld_req     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan.done) begin
          if (mode_q == MODE_DISCOVERY) begin
            // register in lowest free slot with a zero snapshot; drop if
            // already known or table full
            if (!scan.hit && scan.free_ok) begin
              dir_wr.we   = 1'b1;
              dir_wr.idx  = scan.free_idx;
              dir_wr.addr = addr_q;
              snap_we     = 1'b1;
              snap_waddr  = scan.free_idx;
              snap_wdata  = '0;
              ld_disc     = 1'b1;
              state_next  = ST_EMIT;
            end else begin
              state_next = ST_IDLE;
            end
          end else if (scan.hit) begin
            state_next = ST_READ;
          end else begin
            // unknown requester: drop
            state_next = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        // write back only in-order requests
        snap_we    = seq_ok;
        ld_req     = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (ld_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // capture the accepted transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_q  <= mode;
      addr_q  <= client_addr;
      seqn_q  <= req_seqn;
      value_q <= req_value;
    end
  end

  // global count and sum advance only on an in-order request
  always_ff @(posedge clk) begin
    if (rst) begin
      gcount <= '0;
      gsum   <= '0;
    end else if (ld_req && seq_ok) begin
      gcount <= count_inc;
      gsum   <= sum_sat;
    end
  end

  // stage the ack contents
  always_ff @(posedge clk) begin
    if (ld_disc) begin
      res_kind <= MODE_DISCOVERY;
      res_dup  <= 1'b0;
      res_snap <= '0;
    end else if (ld_req) begin
      res_kind <= MODE_REQUEST;
      res_dup  <= !seq_ok;
      res_snap <= seq_ok ? new_snap : snap_rd;
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && ld_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && ld_out) begin
      ack_kind      <= res_kind;
      dest_addr     <= addr_q;
      is_duplicate  <= res_dup;
      ack_value     <= res_snap.value;
      ack_seqn      <= res_snap.seqn;
      ack_num_reqs  <= res_snap.count;
      ack_total_sum <= res_snap.sum;
    end
  end

  // one transaction in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("transaction accepted while previous one in flight");

  // the directory walk only completes while waiting for it
  a_scan_done_state: assert property (@(posedge clk) disable iff (rst)
    scan.done |-> (state == ST_SCAN))
    else $error("directory scan completed outside scan state");

  // discovery ack carries a zero snapshot and is never a duplicate
  a_disc_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (ack_kind == MODE_DISCOVERY)) |->
      (!is_duplicate && ack_seqn == '0 && ack_value == '0 &&
       ack_num_reqs == '0 && ack_total_sum == '0))
    else $error("discovery ack with nonzero snapshot");

  // global count moves by at most one per cycle and never wraps
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(gcount) |-> (gcount == $past(gcount) + 32'd1))
    else $error("global count stepped incorrectly");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives discovery and request transactions into the client dedup accumulator
// and checks every acknowledgement against a cycle-free model of the client
// table, the sequence check and the saturating global count and sum.
// ----------------------------------------------------------------------------
module testbench;
  import csda_pkg::*;

  // Accept-to-ack delay of the request path, the longer of the two, with no output stall
  localparam int ACK_LATENCY = TABLE_SLOTS + 4;

  localparam logic ACK_DISCOVERY = 1'b0;
  localparam logic ACK_REQUEST   = 1'b1;

  // One expected acknowledgement
  typedef struct {
    logic        kind;
    logic [31:0] dest;
    logic        dup;
    logic [31:0] value;
    logic [31:0] seqn;
    logic [31:0] count;
    logic [63:0] sum;
  } ack_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               mode;
  logic [31:0]        client_addr;
  logic [31:0]        req_seqn;
  logic signed [31:0] req_value;
  logic               out_valid;
  logic               out_ready;
  logic               ack_kind;
  logic [31:0]        dest_addr;
  logic               is_duplicate;
  logic signed [31:0] ack_value;
  logic [31:0]        ack_seqn;
  logic [31:0]        ack_num_reqs;
  logic signed [63:0] ack_total_sum;

  // Mirror of the client table and the global accumulators
  logic        cl_valid [TABLE_SLOTS];
  logic [31:0] cl_addr  [TABLE_SLOTS];
  logic [31:0] cl_seqn  [TABLE_SLOTS];
  logic [31:0] cl_value [TABLE_SLOTS];
  logic [31:0] cl_count [TABLE_SLOTS];
  logic [63:0] cl_sum   [TABLE_SLOTS];
  logic [31:0] req_count;
  logic [63:0] run_sum;

  ack_t pending_acks[$];
  int   mismatches;
  bit   calm;

  client_seqn_dedup_accumulator u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .client_addr   (client_addr),
    .req_seqn      (req_seqn),
    .req_value     (req_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ack_kind      (ack_kind),
    .dest_addr     (dest_addr),
    .is_duplicate  (is_duplicate),
    .ack_value     (ack_value),
    .ack_seqn      (ack_seqn),
    .ack_num_reqs  (ack_num_reqs),
    .ack_total_sum (ack_total_sum)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Idle length: mostly none or short, now and then long; none at all when calm
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Apply one accepted transaction to the table mirror; return 1 and the
  // expected ack if the block answers it
  function automatic bit predict_ack(input logic m, input logic [31:0] a,
                                     input logic [31:0] s, input logic [31:0] v,
                                     output ack_t ack);
    int          hit;
    int          free_idx;
    logic [64:0] wide;
    hit      = -1;
    free_idx = -1;
    ack      = '{default: '0};
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (cl_valid[i] && cl_addr[i] == a && hit < 0) hit = i;
      if (!cl_valid[i] && free_idx < 0) free_idx = i;
    end
    if (m == MODE_DISCOVERY) begin
      // Known address or full table: drop silently
      if (hit >= 0 || free_idx < 0) return 0;
      cl_valid[free_idx] = 1'b1;
      cl_addr[free_idx]  = a;
      cl_seqn[free_idx]  = '0;
      cl_value[free_idx] = '0;
      cl_count[free_idx] = '0;
      cl_sum[free_idx]   = '0;
      ack.kind = ACK_DISCOVERY;
      ack.dest = a;
      return 1;
    end
    // Unknown requester: no ack
    if (hit < 0) return 0;
    ack.dup = (cl_seqn[hit] + 32'd1) != s;
    if (!ack.dup) begin
      if (req_count != 32'hFFFF_FFFF) req_count = req_count + 32'd1;
      // Add in 65 bits, clamp when the top two bits disagree
      wide = {run_sum[63], run_sum} + {{33{v[31]}}, v};
      if (wide[64] != wide[63])
        run_sum = wide[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      else
        run_sum = wide[63:0];
      cl_count[hit] = req_count;
      cl_sum[hit]   = run_sum;
      cl_seqn[hit]  = s;
      cl_value[hit] = v;
    end
    ack.kind  = ACK_REQUEST;
    ack.dest  = a;
    ack.value = cl_value[hit];
    ack.seqn  = cl_seqn[hit];
    ack.count = cl_count[hit];
    ack.sum   = cl_sum[hit];
    return 1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Present one transaction, hold it until accepted, predict, then idle for the gap, if any
  task automatic send_item(input logic m, input logic [31:0] a, input logic [31:0] s,
                           input logic [31:0] v, output bit answered);
    ack_t ack;
    int   n;
    in_valid    <= 1'b1;
    mode        <= m;
    client_addr <= a;
    req_seqn    <= s;
    req_value   <= v;
    do @(posedge clk); while (!in_ready);
    answered = predict_ack(m, a, s, v, ack);
    if (answered) begin
      pending_acks.push_back(ack);
    end
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Random transaction: mostly in-order requests from registered clients
  task automatic random_item(output bit answered);
    int          r;
    int          idx;
    logic [31:0] s;
    logic [31:0] v;
    r   = $urandom_range(0, 99);
    idx = $urandom_range(0, TABLE_SLOTS - 1);
    case ($urandom_range(0, 9))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      default: v = $urandom;
    endcase
    if (r < 65) begin
      send_item(MODE_REQUEST, cl_addr[idx], cl_seqn[idx] + 32'd1, v, answered);
    end else if (r < 80) begin
      // Replays, skips and garbage sequence numbers
      case ($urandom_range(0, 2))
        0:       s = cl_seqn[idx];
        1:       s = cl_seqn[idx] + 32'd2;
        default: s = $urandom;
      endcase
      send_item(MODE_REQUEST, cl_addr[idx], s, v, answered);
    end else if (r < 90) begin
      send_item(MODE_REQUEST, $urandom, $urandom, v, answered);
    end else if (r < 95) begin
      send_item(MODE_DISCOVERY, cl_addr[idx], $urandom, v, answered);
    end else begin
      send_item(MODE_DISCOVERY, $urandom, $urandom, v, answered);
    end
  endtask

  // Registration, repeat discovery and requests from strangers
  task automatic test_registration();
    bit a;
    send_item(MODE_DISCOVERY, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, a);
    send_item(MODE_DISCOVERY, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, a);
    send_item(MODE_DISCOVERY, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000, a);
    send_item(MODE_REQUEST,   32'h1234_5678, 32'h0000_0001, 32'h0000_0005, a);
  endtask

  // In-order, replayed and out-of-order sequence numbers with extreme values
  task automatic test_sequencing();
    bit a;
    send_item(MODE_REQUEST, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0011, a);
    send_item(MODE_REQUEST, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, a);
    send_item(MODE_REQUEST, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, a);
    send_item(MODE_REQUEST, 32'h0000_0000, 32'h0000_0001, 32'h8000_0000, a);
    send_item(MODE_REQUEST, 32'h0000_0000, 32'h0000_0002, 32'hFFFF_FFFF, a);
    send_item(MODE_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, a);
    send_item(MODE_REQUEST, 32'hFFFF_FFFF, 32'h0000_0002, 32'h8000_0000, a);
    send_item(MODE_REQUEST, 32'h0000_0000, 32'h0000_0004, 32'h0000_0007, a);
  endtask

  // Fill every slot, then knock on a full table
  task automatic test_table_full();
    bit          a;
    int          used;
    logic [31:0] last;
    used = 0;
    for (int i = 0; i < TABLE_SLOTS; i++) used += cl_valid[i];
    while (used < TABLE_SLOTS) begin
      last = $urandom;
      send_item(MODE_DISCOVERY, last, $urandom, $urandom, a);
      used += a;
    end
    send_item(MODE_DISCOVERY, 32'hA5A5_5A5A, 32'h0, 32'h0, a);
    send_item(MODE_REQUEST, 32'hA5A5_5A5A, 32'h1, 32'h1, a);
    send_item(MODE_REQUEST, last, 32'h1, 32'h0000_0100, a);
  endtask

  // Back-to-back transactions, no idling on the sender side
  task automatic test_back_to_back(input int n);
    bit a;
    calm = 1'b1;
    for (int i = 0; i < n; i++) random_item(a);
    calm = 1'b0;
  endtask

  // Random traffic, n transactions
  task automatic test_random_traffic(input int n);
    bit a;
    for (int i = 0; i < n; i++) random_item(a);
  endtask

  // Sink side: random stalls, including stretches of steady ready
  initial begin
    int n;
    out_ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      n = gap_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Compare each delivered ack with the oldest expectation
  always @(posedge clk) begin : ack_check
    ack_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_acks.size() == 0) begin
        report_mismatch("unexpected ack, dest_addr", 64'(dest_addr), '0);
      end else begin
        want = pending_acks.pop_front();
        if (ack_kind !== want.kind)
          report_mismatch("ack_kind", 64'(ack_kind), 64'(want.kind));
        if (dest_addr !== want.dest)
          report_mismatch("dest_addr", 64'(dest_addr), 64'(want.dest));
        if (is_duplicate !== want.dup)
          report_mismatch("is_duplicate", 64'(is_duplicate), 64'(want.dup));
        if (ack_value !== want.value)
          report_mismatch("ack_value", 64'($unsigned(ack_value)), 64'(want.value));
        if (ack_seqn !== want.seqn)
          report_mismatch("ack_seqn", 64'(ack_seqn), 64'(want.seqn));
        if (ack_num_reqs !== want.count)
          report_mismatch("ack_num_reqs", 64'(ack_num_reqs), 64'(want.count));
        if (ack_total_sum !== want.sum)
          report_mismatch("ack_total_sum", ack_total_sum, want.sum);
      end
    end
  end

  initial begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      cl_valid[i] = 1'b0;
      cl_addr[i]  = '0;
      cl_seqn[i]  = '0;
      cl_value[i] = '0;
      cl_count[i] = '0;
      cl_sum[i]   = '0;
    end
    req_count   = '0;
    run_sum     = '0;
    mismatches  = 0;
    calm        = 1'b0;

    rst         <= 1'b1;
    in_valid    <= 1'b0;
    mode        <= MODE_DISCOVERY;
    client_addr <= '0;
    req_seqn    <= '0;
    req_value   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_registration();
    test_sequencing();
    test_table_full();
    test_back_to_back(80);
    test_random_traffic(800);

    // Drain: wait for every expected ack, then watch for strays
    in_valid <= 1'b0;
    while (pending_acks.size() != 0) @(posedge clk);
    repeat (2 * ACK_LATENCY) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
